// ===== src/aob_pkg.sv =====
// ----------------------------------------------------------------------------
// Alpha-over blend package
// Widths, lane indexes and pipeline word types shared by the blend unit and
// its division stages.
// ----------------------------------------------------------------------------
`default_nettype none

package aob_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OPACITY_W = 17;
  localparam int unsigned N_W       = 25;   // src_alpha * opacity
  localparam int unsigned ALPHA_W   = 24;   // width of the full-alpha denominator
  localparam int unsigned PROD_W    = 32;   // 255*N and dst_alpha*(K-N)
  localparam int unsigned COL_W     = 40;   // colour-weighted terms
  localparam int unsigned NUM_W     = 42;   // rounded dividend
  localparam int unsigned DEN_W     = 33;   // doubled divisor
  localparam int unsigned QUO_W     = 8;    // quotient bits, one per step
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned LANES     = 4;
  localparam int unsigned DIV_LANES = LANES - 1;   // colour lanes only

  localparam logic [OPACITY_W-1:0] OPACITY_ONE    = OPACITY_W'(65536);
  localparam logic [ALPHA_W-1:0]   FULL_ALPHA_DEN = ALPHA_W'(16711680);
  localparam logic [PIX_W-1:0]     ALPHA_OPAQUE   = PIX_W'(255);

  localparam int unsigned LANE_RED   = 0;
  localparam int unsigned LANE_GREEN = 1;
  localparam int unsigned LANE_BLUE  = 2;
  localparam int unsigned LANE_ALPHA = 3;

  typedef logic [LANES-1:0][PIX_W-1:0] aob_pixel_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } aob_lane_t;

  typedef struct packed {
    logic       bypass;
    aob_pixel_t pixel;
  } aob_side_t;

  typedef struct packed {
    aob_lane_t [DIV_LANES-1:0] lane;
    aob_side_t                 side;
  } aob_div_t;

endpackage

`default_nettype wire

// ===== src/aob_div_stage.sv =====
// ----------------------------------------------------------------------------
// Alpha-over blend division stage
// One registered restoring-division step for the three colour lanes, producing
// one quotient bit per lane and carrying the side pixel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_div_stage
  import aob_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire logic     up_valid,
  input  wire aob_div_t up_word,
  output logic          valid,
  output aob_div_t      word
);

  aob_div_t word_next;

  always_comb begin
    logic [NUM_W:0] trial;
    logic [NUM_W:0] sub;
    word_next = up_word;
    for (int l = 0; l < DIV_LANES; l++) begin
      sub   = {{(NUM_W+1-DEN_W){1'b0}}, up_word.lane[l].den} << SHIFT;
      trial = {1'b0, up_word.lane[l].rem} - sub;
      if (!trial[NUM_W]) begin
        word_next.lane[l].rem = trial[NUM_W-1:0];
      end
      word_next.lane[l].quo = {up_word.lane[l].quo[QUO_W-2:0], !trial[NUM_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/alpha_over_blend_unit.sv =====
// ----------------------------------------------------------------------------
// Alpha-over blend unit
// Source-over compositing of a straight-alpha source pixel onto a destination
// pixel, with the source alpha scaled by a layer opacity register.
// ----------------------------------------------------------------------------
// Usage. Each input word carries one source pixel and one destination pixel
// (four bytes each) on in_valid/in_ready; each output word carries the
// blended pixel on out_valid/out_ready. Exactly one output word follows each
// input word, in order.
// The layer opacity is written through cfg_valid/cfg_ready/cfg_data, which is
// always ready; it should only be changed while no pixel is in flight.
// A word passes 13 register stages: four arithmetic stages (opacity product,
// alpha terms, colour products, dividends and the output alpha), eight stages
// of a restoring divider that each settle one colour quotient bit, and the
// output register. One word can be taken per cycle while the receiver keeps
// up; the divider is fully pipelined.
// When the receiver stalls, every stage holding a word freezes while empty
// stages keep filling, so in_ready only falls once the pipeline is full.
// Reset empties the pipeline and sets the opacity to fully opaque.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_over_blend_unit
  import aob_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [OPACITY_W-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     src_red,
  input  wire logic [PIX_W-1:0]     src_green,
  input  wire logic [PIX_W-1:0]     src_blue,
  input  wire logic [PIX_W-1:0]     src_alpha,
  input  wire logic [PIX_W-1:0]     dst_red,
  input  wire logic [PIX_W-1:0]     dst_green,
  input  wire logic [PIX_W-1:0]     dst_blue,
  input  wire logic [PIX_W-1:0]     dst_alpha,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_red,
  output logic [PIX_W-1:0]          out_green,
  output logic [PIX_W-1:0]          out_blue,
  output logic [PIX_W-1:0]          out_alpha
);

  // Widths for the output-alpha division: 2K is 255 shifted left by 17.
  localparam int unsigned ALPHA_NUM_W = PROD_W + 2;
  localparam int unsigned ALPHA_SHIFT = 17;
  localparam int unsigned ALPHA_TOP_W = ALPHA_NUM_W - ALPHA_SHIFT;

  // The opacity register. Writes are always accepted.
  logic [OPACITY_W-1:0] opacity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity <= OPACITY_ONE;
    end else if (cfg_valid && cfg_ready) begin
      opacity <= cfg_data;
    end
  end

  // Pipeline control. A stage advances when it is empty or the stage after
  // it advances, so bubbles are squeezed out while the output is stalled.
  logic adv1, adv2, adv3, adv4, adv_out;
  logic v1, v2, v3, v4;
  logic     div_valid [DIV_STEPS+1];
  aob_div_t div_word  [DIV_STEPS+1];
  logic     div_adv   [DIV_STEPS+1:1];

  assign adv_out              = !out_valid || out_ready;
  assign div_adv[DIV_STEPS+1] = adv_out;
  assign adv4                 = !v4 || div_adv[1];
  assign adv3                 = !v3 || adv4;
  assign adv2                 = !v2 || adv3;
  assign adv1                 = !v1 || adv2;
  assign in_ready             = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv4) begin
        v4 <= v3;
      end
    end
  end

  // Stage 1: capture the pixels and form N = src_alpha * opacity, so that
  // the effective alpha is N / K with K = 255 * 65536.
  aob_pixel_t     src1, dst1;
  logic [N_W-1:0] n1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      src1 <= {src_alpha, src_blue, src_green, src_red};
      dst1 <= {dst_alpha, dst_blue, dst_green, dst_red};
      n1   <= {{(N_W-PIX_W){1'b0}}, src_alpha} * {{(N_W-OPACITY_W){1'b0}}, opacity};
    end
  end

  // Stage 2: classify the alpha and build the two alpha-weighted terms,
  // 255*N for the source and dst_alpha*(K-N) for the destination. In the
  // two bypass cases these terms are meaningless and are ignored later.
  aob_pixel_t        src2, dst2;
  logic              zero2, full2;
  logic [PROD_W-1:0] a2, b2;
  logic [ALPHA_W-1:0] w1;

  assign w1 = FULL_ALPHA_DEN - n1[ALPHA_W-1:0];

  always_ff @(posedge clk) begin
    if (adv2) begin
      src2  <= src1;
      dst2  <= dst1;
      zero2 <= (n1 == '0);
      full2 <= (n1 >= {{(N_W-ALPHA_W){1'b0}}, FULL_ALPHA_DEN});
      a2    <= PROD_W'({n1, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, n1});
      b2    <= {{(PROD_W-PIX_W){1'b0}}, dst1[LANE_ALPHA]} *
               {{(PROD_W-ALPHA_W){1'b0}}, w1};
    end
  end

  // Stage 3: the output-alpha numerator O and, per colour, the products of
  // the channel bytes with the two alpha terms.
  aob_pixel_t        src3, dst3;
  logic              zero3, full3;
  logic [PROD_W-1:0] o3;
  logic [COL_W-1:0]  src_term3 [LANE_ALPHA];
  logic [COL_W-1:0]  dst_term3 [LANE_ALPHA];

  always_ff @(posedge clk) begin
    if (adv3) begin
      src3  <= src2;
      dst3  <= dst2;
      zero3 <= zero2;
      full3 <= full2;
      o3    <= a2 + b2;
      for (int c = 0; c < LANE_ALPHA; c++) begin
        src_term3[c] <= {{(COL_W-PIX_W){1'b0}}, src2[c]} *
                        {{(COL_W-PROD_W){1'b0}}, a2};
        dst_term3[c] <= {{(COL_W-PIX_W){1'b0}}, dst2[c]} *
                        {{(COL_W-PROD_W){1'b0}}, b2};
      end
    end
  end

  // The output alpha is (2O + K) / 2K. As 2K is 255 times 2^17, the top bits
  // of 2O + K are taken first and then divided by 255. That value stays below
  // 2^16, where (y + (y >> 8) + 1) >> 8 gives the quotient by 255 exactly.
  logic [ALPHA_NUM_W-1:0] alpha_num;
  logic [ALPHA_TOP_W-1:0] alpha_top;
  logic [ALPHA_TOP_W:0]   alpha_sum;
  logic [PIX_W-1:0]       alpha4;

  assign alpha_num = {1'b0, o3, 1'b0} + ALPHA_NUM_W'(FULL_ALPHA_DEN);
  assign alpha_top = alpha_num[ALPHA_NUM_W-1:ALPHA_SHIFT];
  assign alpha_sum = {1'b0, alpha_top} + {1'b0, alpha_top >> PIX_W} +
                     (ALPHA_TOP_W+1)'(1);
  assign alpha4    = alpha_sum[2*PIX_W-1:PIX_W];

  // Stage 4: rounded-half-up dividends and divisors. Colour lanes divide
  // 2C + O by 2O, and the output alpha is finished here and rides in the side
  // pixel. Every quotient stays at or below 255, so eight quotient bits
  // suffice and no clamp is needed.
  aob_div_t s4;

  always_ff @(posedge clk) begin
    logic [COL_W-1:0] csum;
    if (adv4) begin
      for (int c = 0; c < LANE_ALPHA; c++) begin
        csum              = src_term3[c] + dst_term3[c];
        s4.lane[c].rem    <= NUM_W'({csum, 1'b0}) + NUM_W'(o3);
        s4.lane[c].den    <= DEN_W'({o3, 1'b0});
        s4.lane[c].quo    <= '0;
      end
      // Zero alpha passes the destination through; alpha of one or more
      // writes the source colour as fully opaque.
      s4.side.bypass <= zero3 || full3;
      if (zero3) begin
        s4.side.pixel <= dst3;
      end else begin
        s4.side.pixel <= {full3 ? ALPHA_OPAQUE : alpha4, src3[LANE_BLUE],
                          src3[LANE_GREEN], src3[LANE_RED]};
      end
    end
  end

  // Stages 5 to 12: one quotient bit per stage, most significant first.
  assign div_valid[0] = v4;
  assign div_word[0]  = s4;

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    assign div_adv[k] = !div_valid[k] || div_adv[k+1];

    aob_div_stage #(
      .SHIFT (DIV_STEPS - k)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .load     (div_adv[k]),
      .up_valid (div_valid[k-1]),
      .up_word  (div_word[k-1]),
      .valid    (div_valid[k]),
      .word     (div_word[k])
    );
  end

  // Output register: choose between the bypass colours and the quotients.
  // The alpha byte always comes from the side pixel.
  aob_div_t last;

  assign last = div_word[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= div_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      if (last.side.bypass) begin
        out_red   <= last.side.pixel[LANE_RED];
        out_green <= last.side.pixel[LANE_GREEN];
        out_blue  <= last.side.pixel[LANE_BLUE];
      end else begin
        out_red   <= last.lane[LANE_RED].quo;
        out_green <= last.lane[LANE_GREEN].quo;
        out_blue  <= last.lane[LANE_BLUE].quo;
      end
      out_alpha <= last.side.pixel[LANE_ALPHA];
    end
  end

`ifndef NO_ASSERTIONS
  // With the output register empty nothing can hold the pipeline back.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A blended pixel always has a non-zero colour divisor.
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (v4 && !s4.side.bypass) |-> (s4.lane[LANE_RED].den != '0))
    else $error("zero divisor entering the divider");

  // Every dividend is below 256 times its divisor, so eight bits hold it.
  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    (v4 && !s4.side.bypass) |->
      (s4.lane[LANE_RED].rem < NUM_W'({s4.lane[LANE_RED].den, {QUO_W{1'b0}}})) &&
      (s4.lane[LANE_GREEN].rem < NUM_W'({s4.lane[LANE_GREEN].den, {QUO_W{1'b0}}})) &&
      (s4.lane[LANE_BLUE].rem < NUM_W'({s4.lane[LANE_BLUE].den, {QUO_W{1'b0}}})))
    else $error("dividend too large for the quotient width");

  // After the last step the red and blue remainders are below their divisors.
  a_remainder_reduced: assert property (@(posedge clk) disable iff (rst)
    (div_valid[DIV_STEPS] && !last.side.bypass) |->
      (last.lane[LANE_RED].rem < NUM_W'(last.lane[LANE_RED].den)) &&
      (last.lane[LANE_BLUE].rem < NUM_W'(last.lane[LANE_BLUE].den)))
    else $error("division did not converge");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_alpha_over_blend_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend unit testbench
// Drives source/destination pixel words into the blend unit, predicts each
// blended word with an exact integer model of source-over compositing or a
// blend typed in by hand, and checks every output word against it, with
// random gaps, receiver stalls and opacity changes between phases.
// ----------------------------------------------------------------------------

module tb_alpha_over_blend_unit;
  import aob_pkg::*;

  // One RGBA pixel, written as 32'hRRGGBBAA in the tables below.
  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] a;
  } rgba_t;

  // A directed row: the opacity it runs under, the pixel pair, and a blend
  // typed in by hand where it can be read straight off the rules.
  typedef struct packed {
    logic [OPACITY_W-1:0] opacity;
    rgba_t                src;
    rgba_t                dst;
    logic                 typed;
    rgba_t                exp_pix;
  } row_t;

  // Receiver stall patterns.
  typedef enum int unsigned {
    RX_OPEN,
    RX_SPARSE,
    RX_THIRD,
    RX_HOLD
  } rx_mode_t;

  localparam int unsigned N_ROWS      = 22;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_WORDS = 56;
  localparam int unsigned TAIL_CYCLES = 20;   // extra watch time after the final drain
  localparam int unsigned STALL_LIMIT = 2000;

  localparam logic [OPACITY_W-1:0] OPACITY_ZERO  = '0;
  localparam logic [OPACITY_W-1:0] OPACITY_TINY  = OPACITY_W'(1);
  localparam logic [OPACITY_W-1:0] OPACITY_HALF  = OPACITY_W'(32768);
  localparam logic [OPACITY_W-1:0] OPACITY_BELOW = OPACITY_W'(65535);
  localparam logic [OPACITY_W-1:0] OPACITY_TOP   = '1;

  // Directed rows. Zero effective alpha must hand back the destination as it
  // stands, and an effective alpha of one or more must give the source colour
  // with an opaque alpha; those rows carry their blend typed in. The rest
  // (partial alpha, the smallest non-zero alpha, opacity just under and above
  // one, colours at the top of the range) are left to the predictor.
  localparam row_t DIRECTED [N_ROWS] = '{
    {OPACITY_ONE,   32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    {OPACITY_ONE,   32'hFFFFFF00, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    {OPACITY_ONE,   32'h12345600, 32'hA55AC33C, 1'b1, 32'hA55AC33C},
    {OPACITY_ONE,   32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
    {OPACITY_ONE,   32'h000000FF, 32'hFFFFFFFF, 1'b1, 32'h000000FF},
    {OPACITY_ONE,   32'hA55AC3FF, 32'h12345678, 1'b1, 32'hA55AC3FF},
    {OPACITY_ONE,   32'hFFFFFF80, 32'h00000000, 1'b0, 32'h00000000},
    {OPACITY_ONE,   32'hFF00FF01, 32'h00FF00FF, 1'b0, 32'h00000000},
    {OPACITY_ONE,   32'h00FF00FE, 32'hFF00FF01, 1'b0, 32'h00000000},
    {OPACITY_ONE,   32'hFFFFFF7F, 32'hFFFFFFFF, 1'b0, 32'h00000000},
    {OPACITY_ONE,   32'h5AA53C80, 32'hC33CA580, 1'b0, 32'h00000000},
    {OPACITY_ZERO,  32'hFFFFFFFF, 32'h11223344, 1'b1, 32'h11223344},
    {OPACITY_ZERO,  32'h00000001, 32'hFF00FF00, 1'b1, 32'hFF00FF00},
    {OPACITY_TINY,  32'hFFFFFF01, 32'h00000000, 1'b0, 32'h00000000},
    {OPACITY_TINY,  32'hFFFFFFFF, 32'h000000FF, 1'b0, 32'h00000000},
    {OPACITY_TOP,   32'h12345680, 32'hFFFFFFFF, 1'b1, 32'h123456FF},
    {OPACITY_TOP,   32'hFF00807F, 32'h00FF8040, 1'b0, 32'h00000000},
    {OPACITY_TOP,   32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
    {OPACITY_BELOW, 32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h00000000},
    {OPACITY_BELOW, 32'h0080FFFF, 32'hFF8000FF, 1'b0, 32'h00000000},
    {OPACITY_HALF,  32'hFFFFFFFF, 32'h000000FF, 1'b0, 32'h00000000},
    {OPACITY_HALF,  32'h80808080, 32'h7F7F7F00, 1'b0, 32'h00000000}
  };

  // Fixed opacities for the first random phases; the last two pick their own.
  localparam logic [OPACITY_W-1:0] PHASE_OPACITY [6] = '{
    OPACITY_ONE, OPACITY_ZERO, OPACITY_TINY, OPACITY_TOP, OPACITY_BELOW, OPACITY_HALF
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [OPACITY_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     src_red, src_green, src_blue, src_alpha;
  logic [PIX_W-1:0]     dst_red, dst_green, dst_blue, dst_alpha;
  logic                 out_valid;
  logic                 out_ready;
  logic [PIX_W-1:0]     out_red, out_green, out_blue, out_alpha;

  // A hand-typed blend travels alongside the input word it belongs to, so
  // that the scoreboard sees it at the same edge as the word is taken.
  logic                 given_typed;
  rgba_t                given_pix;

  rgba_t                pending_blends [$];
  logic [OPACITY_W-1:0] opacity_model;   // opacity as the unit should hold it
  logic [OPACITY_W-1:0] opacity_set;     // last opacity the driver wrote
  int unsigned          faults      = 0;
  int unsigned          burst_left  = 0;
  int unsigned          quiet_cycles = 0;
  rx_mode_t             rx_mode     = RX_OPEN;
  int unsigned          rx_left     = 0;
  int unsigned          rx_tick     = 0;

  alpha_over_blend_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_red   (src_red),
    .src_green (src_green),
    .src_blue  (src_blue),
    .src_alpha (src_alpha),
    .dst_red   (dst_red),
    .dst_green (dst_green),
    .dst_blue  (dst_blue),
    .dst_alpha (dst_alpha),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Blend prediction. Everything is kept as exact integer ratios over
  // K = 255*65536: the effective alpha is N/K with N = src_alpha * opacity,
  // the output alpha is O/(255*K) with O = 255*N + dst_alpha*(K-N), and each
  // colour is C/O with C = 255*cs*N + cd*dst_alpha*(K-N). Both are rounded
  // half up. A colour can never actually exceed 255 (C is at most 255*O), but
  // it is clamped all the same.
  // --------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] weigh_colour(longint unsigned cs, longint unsigned cd,
                                                    longint unsigned n, longint unsigned da,
                                                    longint unsigned o);
    longint unsigned k;
    longint unsigned c;
    longint unsigned v;
    k = FULL_ALPHA_DEN;
    c = 255 * cs * n + cd * da * (k - n);
    v = (2 * c + o) / (2 * o);
    return (v > 255) ? ALPHA_OPAQUE : PIX_W'(v);
  endfunction

  function automatic rgba_t blend_over(rgba_t s, rgba_t d, logic [OPACITY_W-1:0] opacity);
    longint unsigned k;
    longint unsigned n;
    longint unsigned o;
    longint unsigned a;
    rgba_t           res;
    k = FULL_ALPHA_DEN;
    n = longint'(s.a) * longint'(opacity);
    // A fully transparent source leaves the destination untouched.
    if (n == 0)
      return d;
    // Opacity above one is not trimmed on its own: any product that reaches
    // K simply counts as an opaque source.
    if (n >= k) begin
      res   = s;
      res.a = ALPHA_OPAQUE;
      return res;
    end
    o     = 255 * n + longint'(d.a) * (k - n);
    res.r = weigh_colour(s.r, d.r, n, d.a, o);
    res.g = weigh_colour(s.g, d.g, n, d.a, o);
    res.b = weigh_colour(s.b, d.b, n, d.a, o);
    a     = (2 * o + k) / (2 * k);
    res.a = (a > 255) ? ALPHA_OPAQUE : PIX_W'(a);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random pixel content. Alphas lean towards the edges where the blend
  // changes its character; colours are mostly uniform with some extremes.
  // --------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] pick_alpha();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALPHA_OPAQUE;
      2:       return $urandom_range(0, 1) ? PIX_W'($urandom_range(1, 3))
                                           : PIX_W'($urandom_range(252, 254));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_colour();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Words go out in bursts of random length; between bursts there is
  // sometimes an idle gap, and now and then a long burst gives a
  // stretch with no idling at all. Valid is only lowered when a real gap
  // follows, so it is never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input rgba_t s, input rgba_t d, input logic typed, input rgba_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
    end
    in_valid    <= 1'b1;
    src_red     <= s.r;
    src_green   <= s.g;
    src_blue    <= s.b;
    src_alpha   <= s.a;
    dst_red     <= d.r;
    dst_green   <= d.g;
    dst_blue    <= d.b;
    dst_alpha   <= d.a;
    given_typed <= typed;
    given_pix   <= e;
    do
      @(posedge clk);
    while (!in_ready);
    burst_left--;
  endtask

  // Holds the sender back until every blend in flight has come out. The
  // queue is looked at on the falling edge, after all rising-edge updates.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_blends.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // The opacity is only changed with the pipeline empty.
  task automatic write_opacity(input logic [OPACITY_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do
      @(posedge clk);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    opacity_set  = value;
  endtask

  // --------------------------------------------------------------------------
  // Receiver. It runs one stall pattern for a random number of cycles, then
  // picks another: always ready, mostly ready, ready one cycle in three, or
  // held off for the whole stretch bar its last cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(1, 40);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) != 0);
      RX_THIRD:  out_ready <= (rx_tick % 3 == 0);
      default:   out_ready <= (rx_left == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Scoreboard. Taken input words are predicted here (or take their typed
  // blend), the opacity copy follows the configuration channel, and every
  // output word is checked against the oldest blend still pending. Pushing
  // before popping in the one block keeps the queue free of races.
  // --------------------------------------------------------------------------
  task automatic check_byte(input string field, input logic [PIX_W-1:0] want,
                            input logic [PIX_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    rgba_t s;
    rgba_t d;
    rgba_t due;
    if (rst) begin
      opacity_model = OPACITY_ONE;
      pending_blends.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        opacity_model = cfg_data;
      if (in_valid && in_ready) begin
        s = {src_red, src_green, src_blue, src_alpha};
        d = {dst_red, dst_green, dst_blue, dst_alpha};
        pending_blends.push_back(given_typed ? given_pix : blend_over(s, d, opacity_model));
      end
      if (out_valid && out_ready) begin
        if (pending_blends.size() == 0) begin
          $error("output word with no blend pending: %h%h%h%h",
                 out_red, out_green, out_blue, out_alpha);
          faults++;
        end else begin
          due = pending_blends.pop_front();
          check_byte("out_red",   due.r, out_red);
          check_byte("out_green", due.g, out_green);
          check_byte("out_blue",  due.b, out_blue);
          check_byte("out_alpha", due.a, out_alpha);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: the directed table first, then random phases, each under its
  // own opacity. Every phase change drains the pipeline first, and one phase
  // also pauses half way until nothing is left in flight.
  // --------------------------------------------------------------------------
  initial begin
    logic [OPACITY_W-1:0] opacity;
    rgba_t                s;
    rgba_t                d;

    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    src_red     <= '0;
    src_green   <= '0;
    src_blue    <= '0;
    src_alpha   <= '0;
    dst_red     <= '0;
    dst_green   <= '0;
    dst_blue    <= '0;
    dst_alpha   <= '0;
    given_typed <= 1'b0;
    given_pix   <= '0;
    out_ready   <= 1'b0;
    opacity_set  = OPACITY_ONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The first rows run on the opacity left by reset.
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].opacity != opacity_set)
        write_opacity(DIRECTED[i].opacity);
      send_pixel(DIRECTED[i].src, DIRECTED[i].dst, DIRECTED[i].typed, DIRECTED[i].exp_pix);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 6)
        opacity = PHASE_OPACITY[p];
      else if (p == 6)
        opacity = OPACITY_W'($urandom_range(1, 65535));
      else
        opacity = OPACITY_W'($urandom_range(0, 131071));
      write_opacity(opacity);
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (p == 3 && w == PHASE_WORDS / 2)
          wait_drained();
        s.r = pick_colour();
        s.g = pick_colour();
        s.b = pick_colour();
        s.a = pick_alpha();
        d.r = pick_colour();
        d.g = pick_colour();
        d.b = pick_colour();
        d.a = pick_alpha();
        send_pixel(s, d, 1'b0, '0);
      end
    end

    // Let the last blends out, then watch a little longer for stray words.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (faults == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
